// ----- hdl/csq_pkg.sv -----
// ============================================================================
// csq_pkg: shared types and constants for the complex square root colorer
// Request formats, register indexes, widths and the CORDIC angle table.
// ============================================================================
package csq_pkg;

    // Coordinate format, signed Q4.12.
    localparam int COORD_W = 16;
    localparam int FRAC_W  = 12;

    // Squared magnitude and first root.
    localparam int SQ_W = 2 * COORD_W;
    localparam int R_W  = SQ_W / 2;

    // Operands of the second roots, padded to an even width.
    localparam int OP_W   = COORD_W + FRAC_W + ((COORD_W + FRAC_W) % 2);
    localparam int ROOT_W = OP_W / 2;
    localparam int W_W    = ROOT_W + 1;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 16;
    localparam int XY_W         = W_W + 16 + 2;
    localparam int ANG_W        = 22;
    localparam int HUE_W        = 20;
    localparam logic [HUE_W-1:0] HALF_TURN = HUE_W'(524288);

    // Configuration port.
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_RE    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_IM    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_SEL   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_ALPHA = 8'd3;

    typedef enum logic [1:0] {
        HSEL_RE     = 2'd0,
        HSEL_IM     = 2'd1,
        HSEL_MAG    = 2'd2,
        HSEL_RE_ALT = 2'd3
    } hsel_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_re;
        logic signed [COORD_W-1:0] point_im;
        logic                      sheet;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] height;
        logic [7:0]                red;
        logic [7:0]                green;
        logic [7:0]                blue;
        logic [7:0]                alpha;
    } result_t;

    // Arctangent of 2^-step in units of 2^-20 turn.
    function automatic logic [17:0] atan_turn(input int step);
        logic [17:0] a;
        case (step)
            0:       a = 18'd131072;
            1:       a = 18'd77376;
            2:       a = 18'd40884;
            3:       a = 18'd20753;
            4:       a = 18'd10417;
            5:       a = 18'd5213;
            6:       a = 18'd2607;
            7:       a = 18'd1304;
            8:       a = 18'd652;
            9:       a = 18'd326;
            10:      a = 18'd163;
            11:      a = 18'd81;
            12:      a = 18'd41;
            13:      a = 18'd20;
            14:      a = 18'd10;
            15:      a = 18'd5;
            default: a = 18'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- hdl/complex_sqrt_sheet_phase_color_unit.sv -----
// Throughput: one request per cycle; the whole pipeline holds while the
// result is stalled, so a new point is taken whenever the output moves.
// Depth is set by the 16-cell root chain, the 14-cell second root chains and
// the 16-cell CORDIC chain. Reset clears the valid pipeline and loads the
// branch point (1.0, 0), real height and alpha 153.
// ============================================================================
// complex_sqrt_sheet_phase_color_unit: sheet-aware sqrt(z - A) with hue color
// Streams grid points through root and CORDIC cell chains to height and RGBA.
// ============================================================================
module complex_sqrt_sheet_phase_color_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               point_valid,
    output logic                               point_stall,
    input  csq_pkg::point_t                    point,
    output logic                               result_valid,
    input  logic                               result_stall,
    output csq_pkg::result_t                   result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [csq_pkg::COORD_W-1:0]        cfg_data
);

    localparam int CW  = csq_pkg::COORD_W;
    localparam int FB  = csq_pkg::FRAC_W;
    localparam int SQW = csq_pkg::SQ_W;
    localparam int RW  = csq_pkg::R_W;
    localparam int OPW = csq_pkg::OP_W;
    localparam int RTW = csq_pkg::ROOT_W;
    localparam int WW  = csq_pkg::W_W;
    localparam int XW  = csq_pkg::XY_W;
    localparam int AW  = csq_pkg::ANG_W;
    localparam int NC  = csq_pkg::CORDIC_STEPS;
    localparam int HW  = csq_pkg::HUE_W;
    localparam int LAT = 3 + RW + 1 + RTW + 1 + 1 + NC + 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] branch_re_reg;
    logic signed [CW-1:0] branch_im_reg;
    csq_pkg::hsel_t       height_select_reg;
    logic [7:0]           surface_alpha_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_re_reg     <= CW'(4096);
            branch_im_reg     <= '0;
            height_select_reg <= csq_pkg::HSEL_RE;
            surface_alpha_reg <= 8'd153;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                csq_pkg::CFG_BRANCH_RE:     branch_re_reg     <= cfg_data;
                csq_pkg::CFG_BRANCH_IM:     branch_im_reg     <= cfg_data;
                csq_pkg::CFG_HEIGHT_SEL:    height_select_reg <= csq_pkg::hsel_t'(cfg_data[1:0]);
                csq_pkg::CFG_SURFACE_ALPHA: surface_alpha_reg <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves unless a result is held.
    // ------------------------------------------------------------------
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;

    assign en          = !(vld_reg[LAT-1] && result_stall);
    assign point_stall = !en;
    assign vld_next    = {vld_reg[LAT-2:0], point_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign result_valid = vld_reg[LAT-1];

    // ------------------------------------------------------------------
    // Stage 0: saturated difference d = z - A.
    // ------------------------------------------------------------------
    logic signed [CW:0]   diff_re;
    logic signed [CW:0]   diff_im;
    logic signed [CW-1:0] dr_next;
    logic signed [CW-1:0] di_next;
    logic signed [CW-1:0] dr0_reg;
    logic signed [CW-1:0] di0_reg;
    logic                 sheet0_reg;

    always_comb
    begin
        diff_re = {point.point_re[CW-1], point.point_re} - {branch_re_reg[CW-1], branch_re_reg};
        diff_im = {point.point_im[CW-1], point.point_im} - {branch_im_reg[CW-1], branch_im_reg};
        if (diff_re[CW] != diff_re[CW-1])
        begin
            dr_next = {diff_re[CW], {(CW-1){~diff_re[CW]}}};
        end
        else
        begin
            dr_next = diff_re[CW-1:0];
        end
        if (diff_im[CW] != diff_im[CW-1])
        begin
            di_next = {diff_im[CW], {(CW-1){~diff_im[CW]}}};
        end
        else
        begin
            di_next = diff_im[CW-1:0];
        end
    end

    // Stage 1 squares, stage 2 sums them.
    logic signed [2*CW-1:0] sq_re_prod;
    logic signed [2*CW-1:0] sq_im_prod;
    logic [SQW-1:0]         sq_re_reg;
    logic [SQW-1:0]         sq_im_reg;
    logic signed [CW-1:0]   dr1_reg;
    logic                   dineg1_reg;
    logic                   sheet1_reg;
    logic [SQW-1:0]         s_reg;
    logic signed [CW-1:0]   dr2_reg;
    logic                   dineg2_reg;
    logic                   sheet2_reg;

    assign sq_re_prod = dr0_reg * dr0_reg;
    assign sq_im_prod = di0_reg * di0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dr0_reg    <= dr_next;
            di0_reg    <= di_next;
            sheet0_reg <= point.sheet;
            sq_re_reg  <= $unsigned(sq_re_prod);
            sq_im_reg  <= $unsigned(sq_im_prod);
            dr1_reg    <= dr0_reg;
            dineg1_reg <= di0_reg[CW-1];
            sheet1_reg <= sheet0_reg;
            s_reg      <= sq_re_reg + sq_im_reg;
            dr2_reg    <= dr1_reg;
            dineg2_reg <= dineg1_reg;
            sheet2_reg <= sheet1_reg;
        end
    end

    // ------------------------------------------------------------------
    // r = floor(sqrt(s)), the modulus of d.
    // ------------------------------------------------------------------
    logic [RW-1:0]   r_root;
    logic [CW+1:0]   r_side;

    csq_sqrt_chain #(
        .W      (SQW),
        .SIDE_W (CW + 2)
    ) u_mod_root (
        .clk      (clk),
        .en       (en),
        .v        (s_reg),
        .side_in  ({dr2_reg, dineg2_reg, sheet2_reg}),
        .root     (r_root),
        .side_out (r_side)
    );

    // ------------------------------------------------------------------
    // Stage 3: operands of the three half-angle roots.
    // ------------------------------------------------------------------
    logic signed [CW-1:0] dr3;
    logic [CW:0]          r_plus;
    logic [CW:0]          r_minus;
    logic [OPW-1:0]       op_mag_reg;
    logic [OPW-1:0]       op_re_reg;
    logic [OPW-1:0]       op_im_reg;
    logic                 dineg3_reg;
    logic                 sheet3_reg;

    assign dr3     = r_side[CW+1:2];
    assign r_plus  = {1'b0, r_root[CW-1:0]} + {dr3[CW-1], dr3};
    assign r_minus = {1'b0, r_root[CW-1:0]} - {dr3[CW-1], dr3};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_mag_reg <= OPW'({r_root[CW-1:0], {FB{1'b0}}});
            op_re_reg  <= OPW'({r_plus, {(FB-1){1'b0}}});
            op_im_reg  <= OPW'({r_minus, {(FB-1){1'b0}}});
            dineg3_reg <= r_side[1];
            sheet3_reg <= r_side[0];
        end
    end

    logic [RTW-1:0] mag_root;
    logic [RTW-1:0] re_root;
    logic [RTW-1:0] im_root;
    logic [1:0]     re_side;

    csq_sqrt_chain #(
        .W      (OPW),
        .SIDE_W (1)
    ) u_mag_root (
        .clk      (clk),
        .en       (en),
        .v        (op_mag_reg),
        .side_in  (1'b0),
        .root     (mag_root),
        .side_out ()
    );

    csq_sqrt_chain #(
        .W      (OPW),
        .SIDE_W (2)
    ) u_re_root (
        .clk      (clk),
        .en       (en),
        .v        (op_re_reg),
        .side_in  ({dineg3_reg, sheet3_reg}),
        .root     (re_root),
        .side_out (re_side)
    );

    csq_sqrt_chain #(
        .W      (OPW),
        .SIDE_W (1)
    ) u_im_root (
        .clk      (clk),
        .en       (en),
        .v        (op_im_reg),
        .side_in  (1'b0),
        .root     (im_root),
        .side_out ()
    );

    // ------------------------------------------------------------------
    // Stage 4: signs of w and the selected height.
    // ------------------------------------------------------------------
    logic signed [WW-1:0] wr_next;
    logic signed [WW-1:0] wi_next;
    logic signed [CW-1:0] h_next;
    logic signed [WW-1:0] wr_reg;
    logic signed [WW-1:0] wi_reg;
    logic signed [CW-1:0] h_reg;

    always_comb
    begin
        wr_next = re_side[0] ? -$signed({1'b0, re_root}) : $signed({1'b0, re_root});
        wi_next = (re_side[1] ^ re_side[0]) ? -$signed({1'b0, im_root})
                                            : $signed({1'b0, im_root});
        case (height_select_reg)
            csq_pkg::HSEL_IM:  h_next = CW'(wi_next);
            csq_pkg::HSEL_MAG: h_next = $signed(CW'(mag_root));
            default:           h_next = CW'(wr_next);
        endcase
    end

    // Stage 5: fold into the right half plane for the CORDIC.
    logic signed [XW-1:0] x0_reg;
    logic signed [XW-1:0] y0_reg;
    logic signed [AW-1:0] ang0_reg;
    logic [CW:0]          side0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wr_reg <= wr_next;
            wi_reg <= wi_next;
            h_reg  <= h_next;
            if (wr_reg[WW-1])
            begin
                x0_reg   <= XW'(-wr_reg) <<< 16;
                y0_reg   <= XW'(-wi_reg) <<< 16;
                ang0_reg <= $signed(AW'(csq_pkg::HALF_TURN));
            end
            else
            begin
                x0_reg   <= XW'(wr_reg) <<< 16;
                y0_reg   <= XW'(wi_reg) <<< 16;
                ang0_reg <= '0;
            end
            side0_reg <= {h_reg, (wr_reg == '0) && (wi_reg == '0)};
        end
    end

    // ------------------------------------------------------------------
    // CORDIC cell row for arg(w).
    // ------------------------------------------------------------------
    logic signed [XW-1:0] cx_w   [0:NC];
    logic signed [XW-1:0] cy_w   [0:NC];
    logic signed [AW-1:0] cang_w [0:NC];
    logic [CW:0]          cside_w [0:NC];

    assign cx_w[0]    = x0_reg;
    assign cy_w[0]    = y0_reg;
    assign cang_w[0]  = ang0_reg;
    assign cside_w[0] = side0_reg;

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        csq_cordic_cell #(
            .XW     (XW),
            .AW     (AW),
            .STEP   (i),
            .SIDE_W (CW + 1)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .x_in     (cx_w[i]),
            .y_in     (cy_w[i]),
            .ang_in   (cang_w[i]),
            .side_in  (cside_w[i]),
            .x_out    (cx_w[i+1]),
            .y_out    (cy_w[i+1]),
            .ang_out  (cang_w[i+1]),
            .side_out (cside_w[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: hue to RGB and the result register.
    // ------------------------------------------------------------------
    logic [AW-1:0]    ang_sum;
    logic [HW-1:0]    hue;
    logic [HW+2:0]    six;
    logic [2:0]       seg;
    logic [HW:0]      t;
    logic [HW+8:0]    ramp;
    logic [7:0]       xc;
    csq_pkg::result_t res_next;
    csq_pkg::result_t result_reg;

    always_comb
    begin
        ang_sum = $unsigned(cang_w[NC]) + AW'(csq_pkg::HALF_TURN);
        hue     = cside_w[NC][0] ? csq_pkg::HALF_TURN : ang_sum[HW-1:0];
        six     = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        seg     = six[HW+2:HW];
        t       = seg[0] ? ((HW+1)'(1) << HW) - {1'b0, six[HW-1:0]}
                         : {1'b0, six[HW-1:0]};
        ramp    = ({t, 8'b0} - {8'b0, t}) + (HW+9)'(1 << (HW-1));
        xc      = ramp[HW+7:HW];
        res_next.height = cside_w[NC][CW:1];
        res_next.alpha  = surface_alpha_reg;
        case (seg)
            3'd0:
            begin
                res_next.red = 8'd255; res_next.green = xc;     res_next.blue = 8'd0;
            end
            3'd1:
            begin
                res_next.red = xc;     res_next.green = 8'd255; res_next.blue = 8'd0;
            end
            3'd2:
            begin
                res_next.red = 8'd0;   res_next.green = 8'd255; res_next.blue = xc;
            end
            3'd3:
            begin
                res_next.red = 8'd0;   res_next.green = xc;     res_next.blue = 8'd255;
            end
            3'd4:
            begin
                res_next.red = xc;     res_next.green = 8'd0;   res_next.blue = 8'd255;
            end
            default:
            begin
                res_next.red = 8'd255; res_next.green = 8'd0;   res_next.blue = xc;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= res_next;
        end
    end

    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // An accepted point enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> vld_reg[0])
        else $error("accepted point did not enter the pipeline");

    // A held result freezes every stage.
    a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(vld_reg) && $stable(result_reg))
        else $error("pipeline moved while the result was stalled");

    // A full-saturation hue always has one channel at full scale.
    a_full_channel: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.red == 8'd255 || result.green == 8'd255
                          || result.blue == 8'd255))
        else $error("phase color lost its full-scale channel");
`endif

endmodule

// ----- hdl/csq_sqrt_cell.sv -----
// ============================================================================
// csq_sqrt_cell: one digit step of a pipelined integer square root
// Brings down two operand bits, tries the next root bit and registers.
// ============================================================================
module csq_sqrt_cell #(
    parameter int W      = 32,
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W-1:0]         v_in,
    input  logic [W/2+1:0]       rem_in,
    input  logic [W/2-1:0]       root_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic [W-1:0]         v_out,
    output logic [W/2+1:0]       rem_out,
    output logic [W/2-1:0]       root_out,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int RW = W / 2;
    localparam int RB = RW + 2;

    logic [RB-1:0]     cur;
    logic [RB-1:0]     trial;
    logic [RB-1:0]     rem_next;
    logic [RW-1:0]     root_next;
    logic [W-1:0]      v_reg;
    logic [RB-1:0]     rem_reg;
    logic [RW-1:0]     root_reg;
    logic [SIDE_W-1:0] side_reg;

    // Trial subtraction of (4*root + 1) from the shifted remainder.
    always_comb
    begin
        cur   = {rem_in[RB-3:0], v_in[W-1-2*STEP -: 2]};
        trial = {root_in, 2'b01};
        if (cur >= trial)
        begin
            rem_next  = cur - trial;
            root_next = {root_in[RW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = cur;
            root_next = {root_in[RW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg    <= v_in;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign v_out    = v_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ----- hdl/csq_sqrt_chain.sv -----
// ============================================================================
// csq_sqrt_chain: row of square root cells, one root bit per stage
// Gives floor(sqrt(v)) from the last cell and carries side_in along with the operand.
// ============================================================================
module csq_sqrt_chain #(
    parameter int W      = 32,
    parameter int SIDE_W = 1
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [W-1:0]         v,
    input  logic [SIDE_W-1:0]    side_in,
    output logic [W/2-1:0]       root,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int N  = W / 2;
    localparam int RB = N + 2;

    logic [W-1:0]      v_w    [0:N];
    logic [RB-1:0]     rem_w  [0:N];
    logic [N-1:0]      root_w [0:N];
    logic [SIDE_W-1:0] side_w [0:N];

    assign v_w[0]    = v;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign side_w[0] = side_in;

    // One cell per root bit, most significant first.
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        csq_sqrt_cell #(
            .W      (W),
            .STEP   (k),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .v_in     (v_w[k]),
            .rem_in   (rem_w[k]),
            .root_in  (root_w[k]),
            .side_in  (side_w[k]),
            .v_out    (v_w[k+1]),
            .rem_out  (rem_w[k+1]),
            .root_out (root_w[k+1]),
            .side_out (side_w[k+1])
        );
    end

    assign root     = root_w[N];
    assign side_out = side_w[N];

endmodule

// ----- hdl/csq_cordic_cell.sv -----
// ============================================================================
// csq_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates toward the real axis and accumulates the table angle.
// ============================================================================
module csq_cordic_cell #(
    parameter int XW     = 33,
    parameter int AW     = 22,
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [XW-1:0]     x_in,
    input  logic signed [XW-1:0]     y_in,
    input  logic signed [AW-1:0]     ang_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic signed [XW-1:0]     x_out,
    output logic signed [XW-1:0]     y_out,
    output logic signed [AW-1:0]     ang_out,
    output logic [SIDE_W-1:0]        side_out
);

    localparam logic signed [AW-1:0] ATAN = $signed(AW'(csq_pkg::atan_turn(STEP)));

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] x_next;
    logic signed [XW-1:0] y_next;
    logic signed [AW-1:0] ang_next;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic signed [AW-1:0] ang_reg;
    logic [SIDE_W-1:0]    side_reg;

    // Arithmetic shifts floor toward minus infinity.
    always_comb
    begin
        xs = x_in >>> STEP;
        ys = y_in >>> STEP;
        if (!y_in[XW-1])
        begin
            x_next   = x_in + ys;
            y_next   = y_in - xs;
            ang_next = ang_in + ATAN;
        end
        else
        begin
            x_next   = x_in - ys;
            y_next   = y_in + xs;
            ang_next = ang_in - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign ang_out  = ang_reg;
    assign side_out = side_reg;

endmodule

// ----- sim/complex_sqrt_sheet_phase_color_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// complex_sqrt_sheet_phase_color_unit_test: self-checking bench for the colorer
// Streams directed and random grid points through the block, using several
// branch points, height modes and alpha values. An independent predictor
// computes each expected height and color, and a scoreboard compares them in
// order with the results that come out.
// ============================================================================

// Scoreboard: keeps the expected results in order and compares each output.
class sqrt_color_scoreboard;
    csq_pkg::result_t expected_q[$];
    int               mismatches;
    int               checked;

    function void note_point(csq_pkg::result_t exp_res);
        expected_q.push_back(exp_res);
    endfunction

    function void check_result(csq_pkg::result_t got);
        csq_pkg::result_t exp_res;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %h", got);
            return;
        end
        exp_res = expected_q.pop_front();
        checked++;
        if (got.height !== exp_res.height || got.red !== exp_res.red ||
            got.green !== exp_res.green || got.blue !== exp_res.blue ||
            got.alpha !== exp_res.alpha)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: h %0d rgba %0d %0d %0d %0d, expected h %0d rgba %0d %0d %0d %0d",
                         got.height, got.red, got.green, got.blue, got.alpha,
                         exp_res.height, exp_res.red, exp_res.green,
                         exp_res.blue, exp_res.alpha);
        end
    endfunction
endclass

module complex_sqrt_sheet_phase_color_unit_test;

    localparam int LATENCY = 53;

    logic                          clk;
    logic                          rst_n;
    logic                          point_valid;
    logic                          point_stall;
    csq_pkg::point_t               point;
    logic                          result_valid;
    logic                          result_stall;
    csq_pkg::result_t              result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [csq_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [csq_pkg::COORD_W-1:0]   cfg_data;

    // Model copy of the registers.
    logic signed [15:0] model_branch_re;
    logic signed [15:0] model_branch_im;
    logic [1:0]         model_hsel;
    logic [7:0]         model_alpha;

    sqrt_color_scoreboard board;
    bit quiet_mode;
    int points_sent;

    complex_sqrt_sheet_phase_color_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Timeout waiting for results");
        $display("complex_sqrt_sheet_phase_color_unit_test NOT OK");
        $finish;
    end

    // Bitwise integer square root, floor.
    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Phase of w in units of 2^-20 turn by vectoring CORDIC.
    function automatic longint phase_turns(longint re, longint im);
        longint x, y, ang, xs, ys;
        longint atab[16];
        atab = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                 652, 326, 163, 81, 41, 20, 10, 5};
        x = re * 65536;
        y = im * 65536;
        ang = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            ang = 524288;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                ang += atab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                ang -= atab[i];
            end
        end
        return ang;
    endfunction

    // Expected height and color for one grid point.
    function automatic csq_pkg::result_t predict_color(csq_pkg::point_t p);
        csq_pkg::result_t res;
        longint dr, di, wr, wi, mag, h;
        longint unsigned s, r, hue, six, seg, t, x;
        dr = clamp16(longint'(p.point_re) - longint'(model_branch_re));
        di = clamp16(longint'(p.point_im) - longint'(model_branch_im));
        s = dr * dr + di * di;
        r = int_root(s);
        mag = int_root(r << 12);
        wr = int_root((longint'(r) + dr) << 11);
        wi = int_root((longint'(r) - dr) << 11);
        if (di < 0)
            wi = -wi;
        if (p.sheet)
        begin
            wr = -wr;
            wi = -wi;
        end
        case (csq_pkg::hsel_t'(model_hsel))
            csq_pkg::HSEL_IM:  h = wi;
            csq_pkg::HSEL_MAG: h = mag;
            default:           h = wr;
        endcase
        h = clamp16(h);
        if (wr == 0 && wi == 0)
            hue = 524288;
        else
            hue = longint'(phase_turns(wr, wi) + 524288) & 64'hFFFFF;
        six = hue * 6;
        seg = six >> 20;
        t = six & 64'hFFFFF;
        if (seg[0])
            t = 64'h100000 - t;
        x = (t * 255 + 524288) >> 20;
        case (seg)
            0: begin res.red = 8'd255; res.green = 8'(x); res.blue = 8'd0; end
            1: begin res.red = 8'(x); res.green = 8'd255; res.blue = 8'd0; end
            2: begin res.red = 8'd0; res.green = 8'd255; res.blue = 8'(x); end
            3: begin res.red = 8'd0; res.green = 8'(x); res.blue = 8'd255; end
            4: begin res.red = 8'(x); res.green = 8'd0; res.blue = 8'd255; end
            default: begin res.red = 8'd255; res.green = 8'd0; res.blue = 8'(x); end
        endcase
        res.height = h[15:0];
        res.alpha = model_alpha;
        return res;
    endfunction

    // Write one register; the model copy follows the write.
    task automatic write_reg(logic [csq_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            csq_pkg::CFG_BRANCH_RE:     model_branch_re = value;
            csq_pkg::CFG_BRANCH_IM:     model_branch_im = value;
            csq_pkg::CFG_HEIGHT_SEL:    model_hsel = value[1:0];
            csq_pkg::CFG_SURFACE_ALPHA: model_alpha = value[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(logic [15:0] bre, logic [15:0] bim, logic [1:0] hs,
                              logic [7:0] al);
        write_reg(csq_pkg::CFG_BRANCH_RE, bre);
        write_reg(csq_pkg::CFG_BRANCH_IM, bim);
        write_reg(csq_pkg::CFG_HEIGHT_SEL, {14'd0, hs});
        write_reg(csq_pkg::CFG_SURFACE_ALPHA, {8'd0, al});
    endtask

    // Send one point request, with an occasional idle burst before it.
    task automatic send_point(logic [15:0] re, logic [15:0] im, logic sh);
        csq_pkg::point_t p;
        if (!quiet_mode && $urandom_range(0, 5) == 0)
        begin
            point_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        p.point_re = re;
        p.point_im = im;
        p.sheet = sh;
        point_valid <= 1'b1;
        point <= p;
        do
            @(posedge clk);
        while (point_stall);
        board.note_point(predict_color(p));
        points_sent++;
        @(negedge clk);
    endtask

    // Wait until every expected result has come, plus the pipeline depth.
    task automatic drain();
        point_valid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 5) @(negedge clk);
    endtask

    task automatic send_random(int count);
        logic [15:0] re, im;
        for (int i = 0; i < count; i++)
        begin
            re = 16'($urandom);
            im = 16'($urandom);
            // Keep many points near the branch point and the cut.
            case ($urandom_range(0, 3))
                0: re = model_branch_re + $signed(16'($urandom_range(0, 64)) - 16'sd32);
                1: im = model_branch_im + $signed(16'($urandom_range(0, 8)) - 16'sd4);
                default: ;
            endcase
            send_point(re, im, 1'($urandom_range(0, 1)));
        end
    endtask

    // Result side: random stall bursts, checks at the rising edge.
    initial
    begin
        int burst;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
                board.check_result(result);
            @(negedge clk);
            if (burst > 0)
                burst--;
            else if (!quiet_mode && $urandom_range(0, 7) == 0)
                burst = $urandom_range(1, 5);
            result_stall <= (burst > 0);
        end
    end

    initial
    begin
        board = new();
        quiet_mode = 1'b0;
        points_sent = 0;
        rst_n = 1'b0;
        point_valid = 1'b0;
        point = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        model_branch_re = 16'sd4096;
        model_branch_im = 16'sd0;
        model_hsel = csq_pkg::HSEL_RE;
        model_alpha = 8'd153;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed points at reset settings: branch point, extremes, cut, pi.
        send_point(16'sd4096, 16'sd0, 1'b0);
        send_point(16'sd4096, 16'sd0, 1'b1);
        send_point(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_point(16'sh8000, 16'sh8000, 1'b1);
        send_point(16'sh8000, 16'sd0, 1'b0);
        send_point(16'sh8000, 16'sd0, 1'b1);
        send_point(16'sd0, 16'sd4096, 1'b0);
        send_point(16'sd0, -16'sd4096, 1'b1);
        send_point(16'sd8192, 16'sd0, 1'b1);
        send_point(16'hFFFF, 16'hFFFF, 1'b0);
        send_point(16'sh5555, 16'shAAAA, 1'b1);
        drain();

        // Each height mode with extreme, random and zero branch points and alpha values.
        set_config(16'sh7FFF, 16'sh8000, csq_pkg::HSEL_IM, 8'd0);
        send_point(16'sh8000, 16'sh7FFF, 1'b0);
        send_point(16'sh7FFF, 16'sh8000, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_random(150);
        drain();
        set_config(16'sh8000, 16'sh7FFF, csq_pkg::HSEL_MAG, 8'd255);
        send_point(16'sh7FFF, 16'sh8000, 1'b1);
        send_random(150);
        drain();
        set_config(16'($urandom), 16'($urandom), csq_pkg::HSEL_RE_ALT, 8'($urandom));
        write_reg(8'd200, 16'hFFFF);
        send_random(150);
        drain();
        set_config(16'sd0, 16'sd0, csq_pkg::HSEL_RE, 8'd77);
        send_random(150);
        drain();
        set_config(16'($urandom), 16'($urandom), csq_pkg::HSEL_IM, 8'($urandom));
        send_random(150);

        // Final stretch with no idling on either side.
        quiet_mode = 1'b1;
        send_random(150);
        drain();

        $display("Sent %0d points over six register settings; %0d results checked.",
                 points_sent, board.checked);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("complex_sqrt_sheet_phase_color_unit_test OK");
        else
            $display("complex_sqrt_sheet_phase_color_unit_test NOT OK");
        $finish;
    end

endmodule
